FILE: rtl/core/assert_macros.svh
// Assertion helpers for the display init sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/core/dics_pkg.sv
package dics_pkg;

	localparam logic [7:0] MARKER_BYTE      = 8'hFF;
	localparam logic [7:0] DELAY_UNIT_RESET = 8'd10;

	typedef enum logic [1:0] {
		KIND_CMD   = 2'd0,
		KIND_DATA  = 2'd1,
		KIND_DELAY = 2'd2,
		KIND_END   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		PH_CMD   = 3'b001,
		PH_COUNT = 3'b010,
		PH_PARAM = 3'b100
	} phase_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  out_byte;
		logic [15:0] pause_ms;
		logic        last_of_command;
	} result_t;

endpackage

FILE: rtl/core/dics_ctrl.sv
module dics_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        byte_in,
	input  logic [7:0]        unit_ms,
	output logic              res_valid,
	output dics_pkg::result_t res
);

	dics_pkg::phase_t phase_q, phase_d;
	logic [7:0] held_q, held_d;
	logic [7:0] rem_q, rem_d;
	logic [7:0] left;

	always_comb begin
		phase_d   = phase_q;
		held_d    = held_q;
		rem_d     = rem_q;
		res_valid = 1'b0;
		res       = '0;
		left      = rem_q - 8'd1;
		case (phase_q)
			dics_pkg::PH_COUNT: begin
				phase_d   = dics_pkg::PH_CMD;
				res_valid = 1'b1;
				if (held_q == dics_pkg::MARKER_BYTE) begin
					if (byte_in == dics_pkg::MARKER_BYTE) begin
						res.kind = dics_pkg::KIND_END;
					end else begin
						res.kind     = dics_pkg::KIND_DELAY;
						res.pause_ms = 16'(byte_in) * 16'(unit_ms);
					end
				end else begin
					res.kind            = dics_pkg::KIND_CMD;
					res.out_byte        = held_q;
					res.last_of_command = (byte_in == 8'd0);
					if (byte_in != 8'd0) begin
						rem_d   = byte_in;
						phase_d = dics_pkg::PH_PARAM;
					end
				end
			end
			dics_pkg::PH_PARAM: begin
				rem_d               = left;
				res_valid           = 1'b1;
				res.kind            = dics_pkg::KIND_DATA;
				res.out_byte        = byte_in;
				res.last_of_command = (left == 8'd0);
				if (left == 8'd0) begin
					phase_d = dics_pkg::PH_CMD;
				end
			end
			default: begin
				// hold the command until its count arrives
				held_d  = byte_in;
				phase_d = dics_pkg::PH_COUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= dics_pkg::PH_CMD;
			held_q  <= 8'd0;
			rem_q   <= 8'd0;
		end else if (step) begin
			phase_q <= phase_d;
			held_q  <= held_d;
			rem_q   <= rem_d;
		end
	end

endmodule

FILE: rtl/core/display_init_command_sequencer.sv
// Channel   Handshake              Payload
// in        in_valid / in_ready    table_byte
// out       out_valid / out_ready  kind, out_byte, pause_ms, last_of_command
// cfg       cfg_wen                cfg_wdata (delay_unit_ms)
//
// One table byte per cycle, sustained while in_ready stays high. A byte sits in
// the input register after its transfer and is decoded (phase update and the
// 8x8 delay multiply) into the result register once the output can take it,
// and its result transfers from there. Command bytes give no result.
// Reset clears the phase, held command, count and valid flags, and sets
// the delay unit to 10 ms. A stalled output holds the pipeline back
// through in_ready only once the input register is also full.
`include "assert_macros.svh"

module display_init_command_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  table_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  out_byte,
	output logic [15:0] pause_ms,
	output logic        last_of_command,
	input  logic        cfg_wen,
	input  logic [7:0]  cfg_wdata
);

	logic [7:0] unit_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       out_free;
	logic       adv;
	logic       step;
	logic       res_valid;
	dics_pkg::result_t res;
	dics_pkg::result_t res_s2;
	logic       valid_s2;

	assign out_free = !valid_s2 || out_ready;
	assign adv      = !valid_s1 || out_free;
	assign step     = valid_s1 && adv;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_q <= dics_pkg::DELAY_UNIT_RESET;
		end else if (cfg_wen) begin
			unit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && adv) begin
			byte_s1 <= table_byte;
		end
	end

	dics_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.byte_in   (byte_s1),
		.unit_ms   (unit_q),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (step && res_valid) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			// drop the result once transferred
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid) begin
			res_s2 <= res;
		end
	end

	assign out_valid       = valid_s2;
	assign kind            = res_s2.kind;
	assign out_byte        = res_s2.out_byte;
	assign pause_ms        = res_s2.pause_ms;
	assign last_of_command = res_s2.last_of_command;

	`ASSERT_CLK(a_stall_cause, !in_ready |-> (out_valid && !out_ready), "input stalled without output stall")
	`ASSERT_NEVER(a_delay_clean, out_valid && kind == dics_pkg::KIND_DELAY && (out_byte != 8'd0 || last_of_command), "delay result carries byte or last flag")
	`ASSERT_NEVER(a_end_clean, out_valid && kind == dics_pkg::KIND_END && (pause_ms != 16'd0 || out_byte != 8'd0), "end result carries payload")

endmodule
